// ===== src/kwm_pkg.sv =====
// ---------------------------------------------------------------------------
// kwm_pkg
// shared types and constants for the key wrap modular exponentiation block
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package kwm_pkg;
    localparam int MOD_BITS_DEF = 64;
    localparam int KEY_BITS     = 32;
    localparam int EXP_BITS     = 64;
    localparam int SWAP_LO      = 30;
    localparam int SWAP_HI      = 31;

    localparam logic [1:0] REG_MODULUS = 2'd0;
    localparam logic [1:0] REG_PUB_EXP = 2'd1;
    localparam logic [1:0] REG_PRV_EXP = 2'd2;

    localparam logic OP_WRAP   = 1'b0;
    localparam logic OP_UNWRAP = 1'b1;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_REDUCE,
        t_ST_SQUARE,
        t_ST_MULT,
        t_ST_DONE
    } t_state;

    function automatic logic [63:0] swap_bits(input logic [63:0] v);
        logic [63:0] r;
        r = v;
        r[SWAP_LO] = v[SWAP_HI];
        r[SWAP_HI] = v[SWAP_LO];
        return r;
    endfunction
endpackage

// ===== src/key_wrap_modexp.sv =====
// ---------------------------------------------------------------------------
// key_wrap_modexp
// wraps / unwraps a 32-bit key by square-and-multiply modular exponentiation
// ---------------------------------------------------------------------------
// sequence: a base reduction, then per exponent bit a square and, for a set bit,
//   a multiply, each multiply taking a double step per multiplier bit and an add
//   step per set bit; a modulus below two skips straight to a zero result
// throughput: one request at a time, ready again the cycle after the result is
//   taken; a single shared add-mod unit does one double or add step per cycle
// reset: synchronous active low, registers return to modulus 2, e 65537, d 1
`timescale 1ns / 1ps
module key_wrap_modexp #(
    parameter int MOD_BITS = kwm_pkg::MOD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [63:0] i_key_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result_value
);
    localparam int CW = $clog2(MOD_BITS);

    logic [63:0] r_modulus, r_pub_exp, r_prv_exp;
    kwm_pkg::t_state r_state, n_state;
    logic          r_op;
    logic [63:0]   r_exp;
    logic [MOD_BITS-1:0] r_n, r_base, r_r, r_a, r_b;
    logic [MOD_BITS-1:0] r_rem;
    logic [63:0]   r_src;
    logic [5:0]    r_ebit;
    logic [CW-1:0] r_mbit;
    logic [CW:0]   r_rbit;
    logic          r_sub;
    logic          r_small;
    logic [63:0]   r_out;

    // shared add-mod unit: x + y mod n with x, y < n
    logic [MOD_BITS-1:0] au_x, au_y, au_s;
    logic [MOD_BITS:0]   au_sum, au_dif;
    assign au_sum = {1'b0, au_x} + {1'b0, au_y};
    assign au_dif = au_sum - {1'b0, r_n};
    assign au_s   = au_dif[MOD_BITS] ? au_sum[MOD_BITS-1:0] : au_dif[MOD_BITS-1:0];

    // reduction step: rem = 2*rem + bit, minus n if it fits
    logic [MOD_BITS:0] rd_sh, rd_dif;
    assign rd_sh  = {r_rem, r_src[63]};
    assign rd_dif = rd_sh - {1'b0, r_n};

    always_comb begin
        au_x = r_r;
        au_y = r_r;
        if (r_sub) begin
            au_y = r_a;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            kwm_pkg::t_ST_IDLE:   if (i_valid) n_state = kwm_pkg::t_ST_REDUCE;
            kwm_pkg::t_ST_REDUCE: begin
                if (r_small) n_state = kwm_pkg::t_ST_DONE;
                else if (r_rbit == '0) n_state = kwm_pkg::t_ST_SQUARE;
            end
            kwm_pkg::t_ST_SQUARE: begin
                if (r_mbit == '0 && !(r_sub == 1'b0 && r_b[0])) begin
                    if (r_exp[r_ebit]) n_state = kwm_pkg::t_ST_MULT;
                    else if (r_ebit == 6'd0) n_state = kwm_pkg::t_ST_DONE;
                end
            end
            kwm_pkg::t_ST_MULT: begin
                if (r_mbit == '0 && !(r_sub == 1'b0 && r_b[0])) begin
                    if (r_ebit == 6'd0) n_state = kwm_pkg::t_ST_DONE;
                    else n_state = kwm_pkg::t_ST_SQUARE;
                end
            end
            kwm_pkg::t_ST_DONE:   if (i_ready) n_state = kwm_pkg::t_ST_IDLE;
            default:              n_state = kwm_pkg::t_ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready        = (r_state == kwm_pkg::t_ST_IDLE);
        o_valid        = (r_state == kwm_pkg::t_ST_DONE);
        o_result_value = r_out;
    end

    // config registers and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= 64'd2;
            r_pub_exp <= 64'd65537;
            r_prv_exp <= 64'd1;
            r_state   <= kwm_pkg::t_ST_IDLE;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    kwm_pkg::REG_MODULUS: r_modulus <= i_cfg_data;
                    kwm_pkg::REG_PUB_EXP: r_pub_exp <= i_cfg_data;
                    kwm_pkg::REG_PRV_EXP: r_prv_exp <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath sequencer; one multiply walks r_b msb first, each bit takes a
    // double step and, if set, an add step (r_sub marks the add)
    always_ff @(posedge i_clk) begin
        case (r_state)
            kwm_pkg::t_ST_IDLE: begin
                r_op    <= i_op;
                r_n     <= r_modulus[MOD_BITS-1:0];
                r_small <= (r_modulus[MOD_BITS-1:0] < MOD_BITS'(2));
                r_exp   <= (i_op == kwm_pkg::OP_WRAP) ? r_pub_exp : r_prv_exp;
                r_src   <= (i_op == kwm_pkg::OP_WRAP)
                           ? kwm_pkg::swap_bits({32'd0, i_key_value[31:0]}) : i_key_value;
                r_rem   <= '0;
                r_rbit  <= (CW+1)'(64);
                r_out   <= '0;
            end
            kwm_pkg::t_ST_REDUCE: begin
                if (r_rbit != '0) begin
                    r_rem  <= rd_dif[MOD_BITS] ? rd_sh[MOD_BITS-1:0] : rd_dif[MOD_BITS-1:0];
                    r_src  <= {r_src[62:0], 1'b0};
                    r_rbit <= r_rbit - (CW+1)'(1);
                end else begin
                    r_base <= r_rem;
                    r_ebit <= 6'd63;
                    // first square of 1
                    r_a    <= MOD_BITS'(1);
                    r_b    <= MOD_BITS'(1);
                    r_r    <= '0;
                    r_mbit <= CW'(MOD_BITS-1);
                    r_sub  <= 1'b0;
                end
            end
            kwm_pkg::t_ST_SQUARE, kwm_pkg::t_ST_MULT: begin
                if (!r_sub && r_b[r_mbit]) begin
                    r_r   <= au_s;
                    r_sub <= 1'b1;
                end else begin
                    r_sub <= 1'b0;
                    if (r_mbit != '0) begin
                        r_r    <= au_s;
                        r_mbit <= r_mbit - CW'(1);
                    end else begin
                        // multiply done; set up the next one
                        r_mbit <= CW'(MOD_BITS-1);
                        r_r    <= '0;
                        if (r_state == kwm_pkg::t_ST_SQUARE && r_exp[r_ebit]) begin
                            r_a   <= au_s;
                            r_b   <= r_base;
                        end else begin
                            r_a   <= au_s;
                            r_b   <= au_s;
                            if (r_ebit != 6'd0) r_ebit <= r_ebit - 6'd1;
                        end
                        if (n_state == kwm_pkg::t_ST_DONE) begin
                            r_out <= (r_op == kwm_pkg::OP_WRAP) ? 64'(au_s)
                                     : kwm_pkg::swap_bits({32'd0, 32'(au_s)});
                        end
                    end
                end
            end
            default: ;
        endcase
    end
endmodule

// ===== src/kwm_checker.sv =====
// ---------------------------------------------------------------------------
// kwm_checker
// port level checks for key_wrap_modexp
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module kwm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_result_value
);
    // never ready while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready with result pending");
    // result holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_value))
        else $error("result dropped");
    // after a taken result the block is idle again
    a_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> o_ready) else $error("not idle after result");
endmodule

bind key_wrap_modexp kwm_checker u_kwm_checker (.*);

// ===== verif/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// checks key wrap / unwrap by modular exponentiation against a local model,
// with random request gaps, result stalls and several register settings
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// expected wrap / unwrap results, oldest first
class keywrap_scoreboard;
    logic [63:0] modulus_q;
    logic [63:0] pub_exp_q;
    logic [63:0] prv_exp_q;
    logic [63:0] pending_results[$];
    int          n_errors;

    function void reset_regs();
        modulus_q = 64'd2;
        pub_exp_q = 64'd65537;
        prv_exp_q = 64'd1;
        n_errors  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] data);
        case (idx)
            kwm_pkg::REG_MODULUS: modulus_q = data;
            kwm_pkg::REG_PUB_EXP: pub_exp_q = data;
            kwm_pkg::REG_PRV_EXP: prv_exp_q = data;
            default: ;
        endcase
    endfunction

    // exchange of the two key bits that get swapped
    function logic [63:0] flip_pair(logic [63:0] v);
        logic [63:0] r;
        r = v;
        r[kwm_pkg::SWAP_LO] = v[kwm_pkg::SWAP_HI];
        r[kwm_pkg::SWAP_HI] = v[kwm_pkg::SWAP_LO];
        return r;
    endfunction

    function logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] n);
        logic [127:0] p;
        p = a * b;
        p = p % n;
        return p[63:0];
    endfunction

    function logic [63:0] powmod(logic [63:0] base, logic [63:0] ex, logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        if (n < 64'd2) return 64'd0;
        b = base % n;
        r = 64'd1;
        for (int i = 63; i >= 0; i--) begin
            r = mulmod(r, r, n);
            if (ex[i]) r = mulmod(r, b, n);
        end
        return r;
    endfunction

    function void note_request(logic op, logic [63:0] kv);
        logic [63:0] r;
        if (op == kwm_pkg::OP_WRAP) begin
            r = powmod(flip_pair({32'd0, kv[31:0]}), pub_exp_q, modulus_q);
        end else begin
            r = powmod(kv, prv_exp_q, modulus_q);
            r = flip_pair({32'd0, r[31:0]});
        end
        pending_results.push_back(r);
    endfunction

    function void check_result(logic [63:0] got);
        logic [63:0] exp_v;
        if (pending_results.size() == 0) begin
            $error("result_value: none expected, actual %h", got);
            n_errors++;
            return;
        end
        exp_v = pending_results.pop_front();
        if (got !== exp_v) begin
            $error("result_value: expected %h, actual %h", exp_v, got);
            n_errors++;
        end
    endfunction
endclass

module tb;
    localparam int LATENCY   = 8400;
    localparam int MAX_CYCLE = 10_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_op;
    logic [63:0] i_key_value;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_result_value;

    keywrap_scoreboard sb;
    int src_idle_pct;
    int dst_stall_pct;
    int n_cycles;

    key_wrap_modexp dut (.*);

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // result side: random stalls, compare at the rising edge
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_result_value);
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= ($urandom_range(99) >= dst_stall_pct);
    end

    // timeout guard
    always @(posedge i_clk) begin
        if (n_cycles >= MAX_CYCLE) begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic send_request(logic op, logic [63:0] kv);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) @(negedge i_clk);
        i_valid     <= 1'b1;
        i_op        <= op;
        i_key_value <= kv;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_request(op, kv);
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [63:0] n, logic [63:0] e, logic [63:0] d);
        drain();
        write_reg(kwm_pkg::REG_MODULUS, n);
        write_reg(kwm_pkg::REG_PUB_EXP, e);
        write_reg(kwm_pkg::REG_PRV_EXP, d);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        sb = new();
        sb.reset_regs();
        n_cycles      = 0;
        src_idle_pct  = 0;
        dst_stall_pct = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = kwm_pkg::REG_MODULUS;
        i_cfg_data    = 64'd0;
        i_valid       = 1'b0;
        i_op          = kwm_pkg::OP_WRAP;
        i_key_value   = 64'd0;
        i_ready       = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset registers, then extremes and small moduli
        send_request(kwm_pkg::OP_WRAP, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(kwm_pkg::OP_UNWRAP, 64'd3);
        set_regs(64'd0, 64'd5, 64'd7);
        send_request(kwm_pkg::OP_WRAP, 64'h1234_5678);
        send_request(kwm_pkg::OP_UNWRAP, 64'h8000_0000);
        set_regs(64'd1, 64'd3, 64'd3);
        send_request(kwm_pkg::OP_WRAP, 64'h4000_0000);
        send_request(kwm_pkg::OP_UNWRAP, 64'hFFFF_FFFF_FFFF_FFFF);
        set_regs(64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(kwm_pkg::OP_WRAP, 64'hFFFF_FFFF_0000_0000);
        send_request(kwm_pkg::OP_WRAP, 64'h8000_0000);
        send_request(kwm_pkg::OP_UNWRAP, 64'd0);
        send_request(kwm_pkg::OP_UNWRAP, 64'hFFFF_FFFF_FFFF_FFFE);
        set_regs(64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
        send_request(kwm_pkg::OP_WRAP, 64'h4000_0000);
        send_request(kwm_pkg::OP_UNWRAP, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(kwm_pkg::OP_WRAP, 64'd0);
        // textbook rsa pair: n = 3233, e = 17, d = 2753
        set_regs(64'd3233, 64'd17, 64'd2753);
        send_request(kwm_pkg::OP_WRAP, 64'd65);
        send_request(kwm_pkg::OP_UNWRAP, 64'd2790);

        // random phases with different idling and register settings
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
                1: begin src_idle_pct = 49; dst_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  dst_stall_pct = 49; end
                default: begin src_idle_pct = 35; dst_stall_pct = 35; end
            endcase
            set_regs(ph[0] ? rand64() : rand64() >> $urandom_range(62),
                     rand64(), rand64());
            for (int k = 0; k < 21; k++) begin
                send_request(1'($urandom_range(1)), rand64());
            end
        end

        drain();
        repeat (LATENCY) @(posedge i_clk);
        if (sb.n_errors == 0 && sb.pending_results.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
